>>> sv/top_k_frequent_tracker_defines.svh
// assertion macros used by the checker file
`ifndef TOP_K_FREQUENT_TRACKER_DEFINES_SVH
`define TOP_K_FREQUENT_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TKF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tkf assertion failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tkf assertion failed");

`endif

>>> sv/tkf_pkg.sv
package tkf_pkg;

    // parameter defaults
    localparam int K_MAX_DEF      = 8;
    localparam int VALUE_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths and register reset
    localparam int RANK_BITS = 3;
    localparam int CFG_BITS  = 4;
    localparam int K_RESET   = 8;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SEARCH,
        ST_BUBBLE,
        ST_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd;
        logic upd;
        logic srch_step;
        logic bub_step;
        logic emit_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic item_nz;
        logic srch_hit;
        logic srch_end;
        logic bub_done;
        logic emit_more;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> sv/tkf_ctrl.sv
module tkf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_restart,
    output logic             o_s_tready,
    output tkf_pkg::t_dp_cmd o_cmd,
    input  tkf_pkg::t_dp_sts i_sts
);

    tkf_pkg::t_state r_state, n_state;
    logic            r_pend, n_pend;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkf_pkg::ST_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            tkf_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_pend ? tkf_pkg::ST_READ : tkf_pkg::ST_IDLE;
                    n_pend  = 1'b0;
                end
            end
            tkf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_pend       = i_s_restart;
                    n_state      = i_s_restart ? tkf_pkg::ST_CLEAR : tkf_pkg::ST_READ;
                end
            end
            tkf_pkg::ST_READ: begin
                if (i_sts.item_nz) begin
                    o_cmd.rd = 1'b1;
                    n_state  = tkf_pkg::ST_UPDATE;
                end else begin
                    n_state = tkf_pkg::ST_EMIT;
                end
            end
            tkf_pkg::ST_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = tkf_pkg::ST_SEARCH;
            end
            tkf_pkg::ST_SEARCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_hit || i_sts.srch_end) begin
                    n_state = tkf_pkg::ST_BUBBLE;
                end
            end
            tkf_pkg::ST_BUBBLE: begin
                o_cmd.bub_step = 1'b1;
                if (i_sts.bub_done) begin
                    n_state = tkf_pkg::ST_EMIT;
                end
            end
            tkf_pkg::ST_EMIT: begin
                if (!i_sts.emit_more) begin
                    n_state = tkf_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = tkf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tkf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/tkf_datapath.sv
module tkf_datapath #(
    parameter int K_MAX      = tkf_pkg::K_MAX_DEF,
    parameter int VALUE_BITS = tkf_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = tkf_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [tkf_pkg::CFG_BITS-1:0]   i_cfg_wdata,
    input  logic [VALUE_BITS-1:0]          i_s_value,
    input  logic                           i_s_restart,
    input  tkf_pkg::t_dp_cmd               i_cmd,
    output tkf_pkg::t_dp_sts               o_sts,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [tkf_pkg::RANK_BITS-1:0]  o_m_rank,
    output logic [VALUE_BITS-1:0]          o_m_value,
    output logic [COUNT_BITS-1:0]          o_m_count,
    output logic                           o_m_tlast
);

    localparam int KW     = $clog2(K_MAX + 1);
    localparam int DEPTH  = 2 ** VALUE_BITS;
    localparam int K_RST  = (tkf_pkg::K_RESET > K_MAX) ? K_MAX : tkf_pkg::K_RESET;

    // count table
    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_new_cnt;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_we;
    logic [VALUE_BITS-1:0] w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [VALUE_BITS-1:0] r_clr_addr;

    // ranked list, spare slot at index k
    logic [VALUE_BITS-1:0] r_slot_val [K_MAX+1];
    logic [COUNT_BITS-1:0] r_slot_cnt [K_MAX+1];

    logic [VALUE_BITS-1:0] r_value;
    logic [KW-1:0]         r_k;
    logic [KW-1:0]         r_idx;
    logic [KW-1:0]         r_pos;
    logic [KW-1:0]         w_pos_m1;
    logic [KW-1:0]         w_k_m1;

    logic [K_MAX:0]        w_hit;
    logic [K_MAX:0]        w_ooo;
    logic [K_MAX:0]        w_nxt_empty;

    logic [31:0]           w_cfg_ext;
    logic [31:0]           w_eff32;
    logic [KW-1:0]         w_eff;
    logic [31:0]           w_rank32;

    logic                  r_out_valid;
    logic [tkf_pkg::RANK_BITS-1:0] r_out_rank;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_last;

    // effective k of a register write
    assign w_cfg_ext = 32'(i_cfg_wdata);
    assign w_eff32   = (w_cfg_ext == 32'd0) ? 32'd1 :
                       (w_cfg_ext > 32'(K_MAX)) ? 32'(K_MAX) : w_cfg_ext;
    assign w_eff     = w_eff32[KW-1:0];

    assign w_pos_m1  = r_pos - 1'b1;
    assign w_k_m1    = r_k - 1'b1;
    assign w_rank32  = 32'(r_idx);

    // saturating increment of the count just read
    assign w_inc = (r_rd_data == {COUNT_BITS{1'b1}}) ? r_rd_data : r_rd_data + 1'b1;

    // table write port: clearing pass or count update
    always_comb begin
        w_we    = i_cmd.clr_step | i_cmd.upd;
        w_waddr = i_cmd.clr_step ? r_clr_addr : r_value;
        w_wdata = i_cmd.clr_step ? '0 : w_inc;
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_value];
        end
    end

    // per-slot compare cells
    always_comb begin
        w_ooo[0] = 1'b0;
        for (int j = 0; j <= K_MAX; j++) begin
            w_hit[j] = (r_slot_val[j] == r_value);
        end
        for (int j = 1; j <= K_MAX; j++) begin
            w_ooo[j] = (r_slot_cnt[j-1] < r_slot_cnt[j]) ||
                       ((r_slot_cnt[j-1] == r_slot_cnt[j]) && (r_slot_val[j-1] > r_slot_val[j]));
        end
        for (int j = 0; j < K_MAX; j++) begin
            w_nxt_empty[j] = (r_slot_val[j+1] == '0);
        end
        w_nxt_empty[K_MAX] = 1'b1;
    end

    // status to the controller
    always_comb begin
        o_sts.clr_last  = (r_clr_addr == {VALUE_BITS{1'b1}});
        o_sts.item_nz   = (r_value != '0);
        o_sts.srch_hit  = w_hit[r_idx];
        o_sts.srch_end  = (r_idx == w_k_m1);
        o_sts.bub_done  = (r_pos == '0) || !w_ooo[r_pos];
        o_sts.emit_more = (r_idx < r_k) && (r_slot_val[r_idx] != '0);
        o_sts.emit_last = (r_idx == w_k_m1) || w_nxt_empty[r_idx];
        o_sts.out_free  = !r_out_valid || i_m_tready;
    end

    // item registers, indexes and clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= KW'(K_RST);
            r_clr_addr <= '0;
            r_idx      <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_k <= w_eff;
            end
            if (i_cmd.accept) begin
                r_value    <= i_s_value;
                r_clr_addr <= '0;
                r_idx      <= '0;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.upd) begin
                r_new_cnt <= w_inc;
                r_idx     <= '0;
            end
            if (i_cmd.srch_step) begin
                if (w_hit[r_idx]) begin
                    r_pos <= r_idx;
                end else if (r_idx == w_k_m1) begin
                    r_pos <= r_k;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.bub_step) begin
                if (o_sts.bub_done) begin
                    r_idx <= '0;
                end else begin
                    r_pos <= w_pos_m1;
                end
            end
            if (i_cmd.emit_load) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // list slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= K_MAX; j++) begin
                r_slot_val[j] <= '0;
                r_slot_cnt[j] <= '0;
            end
        end else if (i_cfg_wen) begin
            // drop every slot at or above the new k
            for (int j = 0; j <= K_MAX; j++) begin
                if (KW'(j) >= w_eff) begin
                    r_slot_val[j] <= '0;
                    r_slot_cnt[j] <= '0;
                end
            end
        end else if (i_cmd.accept && i_s_restart) begin
            for (int j = 0; j <= K_MAX; j++) begin
                r_slot_val[j] <= '0;
                r_slot_cnt[j] <= '0;
            end
        end else if (i_cmd.srch_step) begin
            // refresh the found entry or load the spare slot
            for (int j = 0; j <= K_MAX; j++) begin
                if (w_hit[r_idx] && (KW'(j) == r_idx)) begin
                    r_slot_cnt[j] <= r_new_cnt;
                end else if (!w_hit[r_idx] && (r_idx == w_k_m1) && (KW'(j) == r_k)) begin
                    r_slot_val[j] <= r_value;
                    r_slot_cnt[j] <= r_new_cnt;
                end
            end
        end else if (i_cmd.bub_step) begin
            if (o_sts.bub_done) begin
                // spare slot falls out of the list
                for (int j = 0; j <= K_MAX; j++) begin
                    if (KW'(j) == r_k) begin
                        r_slot_val[j] <= '0;
                        r_slot_cnt[j] <= '0;
                    end
                end
            end else begin
                // swap the pair at the bubble position
                for (int j = 0; j < K_MAX; j++) begin
                    if (KW'(j) == w_pos_m1) begin
                        r_slot_val[j] <= r_slot_val[j+1];
                        r_slot_cnt[j] <= r_slot_cnt[j+1];
                    end
                end
                for (int j = 1; j <= K_MAX; j++) begin
                    if (KW'(j) == r_pos) begin
                        r_slot_val[j] <= r_slot_val[j-1];
                        r_slot_cnt[j] <= r_slot_cnt[j-1];
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_rank  <= w_rank32[tkf_pkg::RANK_BITS-1:0];
            r_out_value <= r_slot_val[r_idx];
            r_out_count <= r_slot_cnt[r_idx];
            r_out_last  <= o_sts.emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_rank   = r_out_rank;
    assign o_m_value  = r_out_value;
    assign o_m_count  = r_out_count;
    assign o_m_tlast  = r_out_last;

endmodule

>>> sv/top_k_frequent_tracker.sv
// Streaming top-k frequency tracker. Each input transfer carries one value; the block bumps
// that value's saturating count in a table of 2^VALUE_BITS counts, moves the value into a
// ranked list of up to k entries (count descending, smaller value first on ties, value 0
// means empty) and then sends the whole list as one output transfer per entry, rank 0 first,
// with tlast on the final entry; an empty list sends nothing. An item is accepted, its count
// is read from the count table and the new count written, search steps run up to the found
// slot (or over all k slots), bubble steps move the entry upward, and emit steps hand out the
// entries, each one waiting out any output stall; a zero value skips the count read and
// write, search and bubble. The input is taken again only after the previous item's list
// has been handed to the output register.
// The count table has a single write port, so after reset, and after an item with restart
// set, a clearing pass writes all 2^VALUE_BITS entries to zero before the item goes on.
// Write k_in_use only while the block is idle.
module top_k_frequent_tracker #(
    parameter int K_MAX      = tkf_pkg::K_MAX_DEF,
    parameter int VALUE_BITS = tkf_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = tkf_pkg::COUNT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // k_in_use register
    input  logic                                   i_cfg_wen,
    input  logic [tkf_pkg::CFG_BITS-1:0]           i_cfg_wdata,
    // input stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0]  i_s_tdata,  // value
    input  logic [0:0]                             i_s_tuser,  // restart
    // output stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((tkf_pkg::RANK_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8-1:0]
                                                   o_m_tdata,  // rank, entry_value, entry_count
    output logic                                   o_m_tlast   // last
);

    localparam int OUT_W = ((tkf_pkg::RANK_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

    tkf_pkg::t_dp_cmd              w_cmd;
    tkf_pkg::t_dp_sts              w_sts;
    logic [tkf_pkg::RANK_BITS-1:0] w_rank;
    logic [VALUE_BITS-1:0]         w_value;
    logic [COUNT_BITS-1:0]         w_count;

    // controller
    tkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_restart (i_s_tuser[0]),
        .o_s_tready  (o_s_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // datapath
    tkf_datapath #(
        .K_MAX      (K_MAX),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_value   (i_s_tdata[VALUE_BITS-1:0]),
        .i_s_restart (i_s_tuser[0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_rank    (w_rank),
        .o_m_value   (w_value),
        .o_m_count   (w_count),
        .o_m_tlast   (o_m_tlast)
    );

    // pack result fields, rank in the lowest bits
    assign o_m_tdata = OUT_W'({w_count, w_value, w_rank});

endmodule

>>> sv/tkf_checker.sv
`include "top_k_frequent_tracker_defines.svh"

module tkf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [tkf_pkg::RANK_BITS-1:0] i_m_rank,
    input logic                          i_m_tlast
);

    // stalled result holds its rank
    `TKF_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_rank))

    // one item at a time: an input transfer closes the input for the next cycle
    `TKF_ASSERT_NEXT(a_busy_after_in, i_s_tvalid && i_s_tready, !i_s_tready)

    // no new item while a list is still going out
    `TKF_ASSERT_IMPL(a_no_in_mid_list, i_m_tvalid && !i_m_tlast, !i_s_tready)

    // entries of one list follow back to back with rising rank
    `TKF_ASSERT_NEXT(a_rank_step, i_m_tvalid && i_m_tready && !i_m_tlast,
        i_m_tvalid && (i_m_rank == $past(i_m_rank) + 3'd1))

endmodule

bind top_k_frequent_tracker tkf_checker u_tkf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_rank   (o_m_tdata[2:0]),
    .i_m_tlast  (o_m_tlast)
);
